// ===== sv/fsa_pkg.sv =====
// Shared constants, codes and cell control type for the segment allocator.
package fsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int ID_BITS_DEF      = 8;
  localparam int REQ_W            = 16;
  localparam int STATUS_W         = 3;
  localparam int ACTION_W         = 2;
  localparam int MODE_W           = 2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ID_USED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD       = 3'd4;

  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  typedef struct packed {
    logic shift;  // take the right neighbour's entry
    logic wr0;    // load the first write port
    logic wr1;    // load the second write port
  } cell_ctl_t;

endpackage

// ===== sv/fsa_cell.sv =====
// One table slot: holds a segment entry and hands it to its left neighbour.
module fsa_cell #(
  parameter int ADDR_BITS = fsa_pkg::ADDR_BITS_DEF,
  parameter int ID_BITS   = fsa_pkg::ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  fsa_pkg::cell_ctl_t    ctl_i,
  input  logic [ADDR_BITS-1:0]  nb_first_i,
  input  logic [ADDR_BITS-1:0]  nb_last_i,
  input  logic [ID_BITS-1:0]    nb_owner_i,
  input  logic                  nb_taken_i,
  input  logic [ADDR_BITS-1:0]  w0_first_i,
  input  logic [ADDR_BITS-1:0]  w0_last_i,
  input  logic [ID_BITS-1:0]    w0_owner_i,
  input  logic                  w0_taken_i,
  input  logic [ADDR_BITS-1:0]  w1_first_i,
  input  logic [ADDR_BITS-1:0]  w1_last_i,
  input  logic [ID_BITS-1:0]    w1_owner_i,
  input  logic                  w1_taken_i,
  output logic [ADDR_BITS-1:0]  first_o,
  output logic [ADDR_BITS-1:0]  last_o,
  output logic [ID_BITS-1:0]    owner_o,
  output logic                  taken_o
);

  logic [ADDR_BITS-1:0] first_q, last_q;
  logic [ID_BITS-1:0]   owner_q;
  logic                 taken_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr0) begin
      first_q <= w0_first_i;
      last_q  <= w0_last_i;
      owner_q <= w0_owner_i;
      taken_q <= w0_taken_i;
    end else if (ctl_i.wr1) begin
      first_q <= w1_first_i;
      last_q  <= w1_last_i;
      owner_q <= w1_owner_i;
      taken_q <= w1_taken_i;
    end else if (ctl_i.shift) begin
      first_q <= nb_first_i;
      last_q  <= nb_last_i;
      owner_q <= nb_owner_i;
      taken_q <= nb_taken_i;
    end
  end

  assign first_o = first_q;
  assign last_o  = last_q;
  assign owner_o = owner_q;
  assign taken_o = taken_q;

endmodule

// ===== sv/fit_segment_allocator.sv =====
// Segment table allocator: a chain of slot cells rotated past one controller.
//
//  channel   ports                                        direction
//  command   start_i, busy_o, action_i .. request_size_i  in
//  result    done_o, status_o, grant_*_o, free_total_o    out
//  config    cfg_we_i, cfg_wdata_i                        in
//
// Append and the unused action answer in the cycle after the start.
// Allocate and free make one pass of the slot chain to search and a second
// to rewrite (split or merge) in place; free then writes its last entry back.
// An allocate or free refused by the search answers once the first pass ends.
// Reset clears the count, the free total and the mode; slots are not cleared.
// The receiver cannot stall: done_o is a single-cycle strobe.
module fit_segment_allocator #(
  parameter int MAX_SEGMENTS = fsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = fsa_pkg::ADDR_BITS_DEF,
  parameter int ID_BITS      = fsa_pkg::ID_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           cfg_we_i,
  input  logic [fsa_pkg::MODE_W-1:0]     cfg_wdata_i,
  input  logic [fsa_pkg::ACTION_W-1:0]   action_i,
  input  logic [ADDR_BITS-1:0]           part_start_i,
  input  logic [ADDR_BITS-1:0]           part_end_i,
  input  logic [ID_BITS-1:0]             process_id_i,
  input  logic [fsa_pkg::REQ_W-1:0]      request_size_i,
  output logic                           done_o,
  output logic [fsa_pkg::STATUS_W-1:0]   status_o,
  output logic [ADDR_BITS-1:0]           grant_start_o,
  output logic [ADDR_BITS-1:0]           grant_end_o,
  output logic [ADDR_BITS:0]             free_total_o
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int FT_W  = ADDR_BITS + 1;
  localparam int SZ_W  = (ADDR_BITS + 1 > fsa_pkg::REQ_W) ? ADDR_BITS + 1 : fsa_pkg::REQ_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EDIT, S_FLUSH} state_e;

  state_e state_q;

  // cell row
  logic [ADDR_BITS-1:0] c_first [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] c_last  [MAX_SEGMENTS];
  logic [ID_BITS-1:0]   c_owner [MAX_SEGMENTS];
  logic                 c_taken [MAX_SEGMENTS];
  fsa_pkg::cell_ctl_t   c_ctl   [MAX_SEGMENTS];

  // write ports shared by all cells
  logic                 shift, wr0, wr1;
  logic [CNT_W-1:0]     w0_idx, w1_idx;
  logic [ADDR_BITS-1:0] e0_first, e0_last, e1_first, e1_last;
  logic [ID_BITS-1:0]   e0_owner;
  logic                 e0_taken;

  // controller registers
  logic [CNT_W-1:0]            cnt_q, u_q, e_q, pos_q, own_q, pick_q;
  logic                        own_f_q, fit_f_q;
  logic [SZ_W-1:0]             best_q;
  logic [FT_W-1:0]             fsum_q, acc_sum_q;
  logic [fsa_pkg::MODE_W-1:0]  mode_q;
  logic [fsa_pkg::ACTION_W-1:0] act_q;
  logic [ID_BITS-1:0]          id_q;
  logic [fsa_pkg::REQ_W-1:0]   size_q;
  logic [ADDR_BITS-1:0]        gs_q, ge_q;
  logic                        acc_v_q, acc_taken_q;
  logic [ADDR_BITS-1:0]        acc_first_q, acc_last_q;
  logic [ID_BITS-1:0]          acc_owner_q;
  logic                        done_q;
  logic [fsa_pkg::STATUS_W-1:0] status_q;
  logic [ADDR_BITS-1:0]        gso_q, geo_q;
  logic [FT_W-1:0]             ft_q;

  // head view
  logic [ADDR_BITS-1:0] h_first, h_last;
  logic [ID_BITS-1:0]   h_owner;
  logic                 h_taken;
  logic [SZ_W-1:0]      h_size, req, ge_w, acc_size, add_sz;
  logic                 h_fits, at_pick, at_own, hm_taken, merge, split;
  logic [ID_BITS-1:0]   hm_owner;
  logic [ADDR_BITS-1:0] ge;
  logic [FT_W:0]        sum_ext, app_ext;
  logic [FT_W-1:0]      sum_sat, app_sat, app_sz;

  assign h_first = c_first[0];
  assign h_last  = c_last[0];
  assign h_owner = c_owner[0];
  assign h_taken = c_taken[0];

  always_comb begin
    req      = SZ_W'(size_q);
    h_size   = SZ_W'(h_last) - SZ_W'(h_first) + SZ_W'(1);
    acc_size = SZ_W'(acc_last_q) - SZ_W'(acc_first_q) + SZ_W'(1);
    h_fits   = !h_taken && (h_size >= req);
    at_pick  = (pos_q == pick_q);
    at_own   = (pos_q == own_q);
    ge_w     = SZ_W'(h_first) + req - SZ_W'(1);
    ge       = ge_w[ADDR_BITS-1:0];
    split    = best_q > req;
    hm_taken = h_taken && !at_own;
    hm_owner = at_own ? '0 : h_owner;
    // no wrap: a segment ending at the top address never touches the next
    merge    = acc_v_q && !acc_taken_q && !hm_taken &&
               ((FT_W'(acc_last_q) + FT_W'(1)) == FT_W'(h_first));

    shift    = 1'b0;
    wr0      = 1'b0;
    wr1      = 1'b0;
    w0_idx   = u_q + e_q - CNT_W'(1);
    w1_idx   = u_q + e_q;
    e0_first = h_first;
    e0_last  = h_last;
    e0_owner = h_owner;
    e0_taken = h_taken;
    e1_first = ge + ADDR_BITS'(1);
    e1_last  = h_last;
    add_sz   = '0;

    case (state_q)
      S_IDLE: begin
        // append writes at the current end of the table
        w0_idx   = cnt_q;
        e0_first = part_start_i;
        e0_last  = part_end_i;
        e0_owner = '0;
        e0_taken = 1'b0;
        wr0      = start_i && (action_i == fsa_pkg::ACT_APPEND) &&
                   (part_end_i >= part_start_i) && (cnt_q != CNT_W'(MAX_SEGMENTS));
      end
      S_SCAN: begin
        // rotate the row once, re-emitting each entry unchanged
        if (u_q != '0) begin
          shift = 1'b1;
          wr0   = 1'b1;
        end
      end
      S_EDIT: begin
        if (u_q != '0) begin
          shift = 1'b1;
          if (act_q == fsa_pkg::ACT_ALLOC) begin
            wr0 = 1'b1;
            if (at_pick) begin
              e0_last  = ge;
              e0_owner = id_q;
              e0_taken = 1'b1;
              wr1      = split;
              add_sz   = split ? (best_q - req) : '0;
            end else begin
              add_sz = h_taken ? '0 : h_size;
            end
          end else if (acc_v_q && !merge) begin
            wr0      = 1'b1;
            e0_first = acc_first_q;
            e0_last  = acc_last_q;
            e0_owner = acc_owner_q;
            e0_taken = acc_taken_q;
            add_sz   = acc_taken_q ? '0 : acc_size;
          end
        end
      end
      S_FLUSH: begin
        wr0      = 1'b1;
        w0_idx   = e_q;
        e0_first = acc_first_q;
        e0_last  = acc_last_q;
        e0_owner = acc_owner_q;
        e0_taken = acc_taken_q;
        add_sz   = acc_taken_q ? '0 : acc_size;
      end
      default: ;
    endcase

    sum_ext = {1'b0, acc_sum_q} + {1'b0, FT_W'(add_sz)};
    sum_sat = sum_ext[FT_W] ? '1 : sum_ext[FT_W-1:0];
    app_sz  = FT_W'(part_end_i) - FT_W'(part_start_i) + FT_W'(1);
    app_ext = {1'b0, fsum_q} + {1'b0, app_sz};
    app_sat = app_ext[FT_W] ? '1 : app_ext[FT_W-1:0];
  end

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    localparam int NB = (i + 1 < MAX_SEGMENTS) ? i + 1 : i;

    always_comb begin
      c_ctl[i].shift = shift;
      c_ctl[i].wr0   = wr0 && (w0_idx == CNT_W'(i));
      c_ctl[i].wr1   = wr1 && (w1_idx == CNT_W'(i));
    end

    fsa_cell #(
      .ADDR_BITS (ADDR_BITS),
      .ID_BITS   (ID_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (c_ctl[i]),
      .nb_first_i (c_first[NB]),
      .nb_last_i  (c_last[NB]),
      .nb_owner_i (c_owner[NB]),
      .nb_taken_i (c_taken[NB]),
      .w0_first_i (e0_first),
      .w0_last_i  (e0_last),
      .w0_owner_i (e0_owner),
      .w0_taken_i (e0_taken),
      .w1_first_i (e1_first),
      .w1_last_i  (e1_last),
      .w1_owner_i ('0),
      .w1_taken_i (1'b0),
      .first_o    (c_first[i]),
      .last_o     (c_last[i]),
      .owner_o    (c_owner[i]),
      .taken_o    (c_taken[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      fsum_q  <= '0;
      mode_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            mode_q <= cfg_wdata_i;
          end
          if (start_i) begin
            act_q  <= action_i;
            id_q   <= process_id_i;
            size_q <= request_size_i;
            gso_q  <= '0;
            geo_q  <= '0;
            u_q    <= cnt_q;
            e_q    <= '0;
            pos_q  <= '0;
            own_f_q <= 1'b0;
            fit_f_q <= 1'b0;
            case (action_i)
              fsa_pkg::ACT_APPEND: begin
                done_q <= 1'b1;
                if (wr0) begin
                  status_q <= fsa_pkg::ST_OK;
                  cnt_q    <= cnt_q + CNT_W'(1);
                  fsum_q   <= app_sat;
                  ft_q     <= app_sat;
                end else begin
                  status_q <= fsa_pkg::ST_BAD;
                  ft_q     <= fsum_q;
                end
              end
              fsa_pkg::ACT_ALLOC, fsa_pkg::ACT_FREE: begin
                state_q <= S_SCAN;
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= fsa_pkg::ST_BAD;
                ft_q     <= fsum_q;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (u_q != '0) begin
            u_q   <= u_q - CNT_W'(1);
            e_q   <= e_q + CNT_W'(1);
            pos_q <= pos_q + CNT_W'(1);
            if (!own_f_q && h_taken && (h_owner == id_q)) begin
              own_f_q <= 1'b1;
              own_q   <= pos_q;
            end
            if (h_fits) begin
              if (mode_q == fsa_pkg::MODE_BEST) begin
                if (!fit_f_q || (h_size < best_q)) begin
                  fit_f_q <= 1'b1;
                  pick_q  <= pos_q;
                  best_q  <= h_size;
                end
              end else if (mode_q == fsa_pkg::MODE_WORST) begin
                if (!fit_f_q || (h_size > best_q)) begin
                  fit_f_q <= 1'b1;
                  pick_q  <= pos_q;
                  best_q  <= h_size;
                end
              end else if (!fit_f_q) begin
                fit_f_q <= 1'b1;
                pick_q  <= pos_q;
                best_q  <= h_size;
              end
            end
          end else begin
            // row is home again: decide, then rewrite on a second pass
            u_q       <= cnt_q;
            e_q       <= '0;
            pos_q     <= '0;
            acc_v_q   <= 1'b0;
            acc_sum_q <= '0;
            ft_q      <= fsum_q;
            if (act_q == fsa_pkg::ACT_ALLOC) begin
              if (own_f_q) begin
                done_q   <= 1'b1;
                status_q <= fsa_pkg::ST_ID_USED;
                state_q  <= S_IDLE;
              end else if (size_q == '0) begin
                done_q   <= 1'b1;
                status_q <= fsa_pkg::ST_BAD;
                state_q  <= S_IDLE;
              end else if (!fit_f_q) begin
                done_q   <= 1'b1;
                status_q <= fsa_pkg::ST_NO_FIT;
                state_q  <= S_IDLE;
              end else if (split && (cnt_q == CNT_W'(MAX_SEGMENTS))) begin
                done_q   <= 1'b1;
                status_q <= fsa_pkg::ST_BAD;
                state_q  <= S_IDLE;
              end else begin
                state_q <= S_EDIT;
              end
            end else if (!own_f_q) begin
              done_q   <= 1'b1;
              status_q <= fsa_pkg::ST_NOT_FOUND;
              state_q  <= S_IDLE;
            end else begin
              state_q <= S_EDIT;
            end
          end
        end
        S_EDIT: begin
          if (u_q != '0) begin
            u_q       <= u_q - CNT_W'(1);
            pos_q     <= pos_q + CNT_W'(1);
            acc_sum_q <= sum_sat;
            if (act_q == fsa_pkg::ACT_ALLOC) begin
              e_q <= e_q + CNT_W'(1) + CNT_W'(wr1);
              if (at_pick) begin
                gs_q <= h_first;
                ge_q <= ge;
              end
            end else begin
              e_q <= e_q + CNT_W'(wr0);
              if (merge) begin
                acc_last_q <= h_last;
              end else begin
                acc_v_q     <= 1'b1;
                acc_first_q <= h_first;
                acc_last_q  <= h_last;
                acc_owner_q <= hm_owner;
                acc_taken_q <= hm_taken;
              end
            end
          end else if (act_q == fsa_pkg::ACT_ALLOC) begin
            cnt_q    <= e_q;
            fsum_q   <= acc_sum_q;
            ft_q     <= acc_sum_q;
            gso_q    <= gs_q;
            geo_q    <= ge_q;
            done_q   <= 1'b1;
            status_q <= fsa_pkg::ST_OK;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          cnt_q    <= e_q + CNT_W'(1);
          fsum_q   <= sum_sat;
          ft_q     <= sum_sat;
          done_q   <= 1'b1;
          status_q <= fsa_pkg::ST_OK;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign grant_start_o = gso_q;
  assign grant_end_o   = geo_q;
  assign free_total_o  = ft_q;

endmodule

// ===== sv/fsa_checker.sv =====
// Port-level checks for the segment allocator, bound to the top level.
module fsa_checker #(
  parameter int ADDR_BITS = fsa_pkg::ADDR_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [fsa_pkg::ACTION_W-1:0]  action_i,
  input logic                          done_o,
  input logic [fsa_pkg::STATUS_W-1:0]  status_o,
  input logic [ADDR_BITS-1:0]          grant_start_o,
  input logic [ADDR_BITS-1:0]          grant_end_o,
  input logic [ADDR_BITS:0]            free_total_o
);

  // a finished search or rewrite always ends in a result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o) else $error("busy dropped without a result");

  // append transfers answer in the next cycle
  a_append_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == fsa_pkg::ACT_APPEND) |=> (done_o && !busy_o))
    else $error("append result late");

  // table searches hold the command port
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i == fsa_pkg::ACT_ALLOC || action_i == fsa_pkg::ACT_FREE))
    |=> (busy_o && !done_o)) else $error("search did not hold busy");

  // failed items grant nothing
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != fsa_pkg::ST_OK) |-> (grant_start_o == '0 && grant_end_o == '0))
    else $error("grant on failure");

  // free total holds still across back-to-back rejected results
  a_total_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) && status_o != fsa_pkg::ST_OK && $past(status_o) != fsa_pkg::ST_OK)
    |-> $stable(free_total_o)) else $error("free total moved on rejects");

endmodule

bind fit_segment_allocator fsa_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_fsa_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the segment allocator: directed and random commands.
module tb;

  localparam int NSEG = fsa_pkg::MAX_SEGMENTS_DEF;
  localparam int AW = fsa_pkg::ADDR_BITS_DEF;
  localparam int IW = fsa_pkg::ID_BITS_DEF;
  localparam int MW = fsa_pkg::MODE_W;
  localparam int CW = fsa_pkg::ACTION_W;
  localparam int RW = fsa_pkg::REQ_W;
  localparam int SW = fsa_pkg::STATUS_W;
  localparam int FREE_CAP = (1 << (AW + 1)) - 1;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 100;

  localparam logic [MW-1:0] MODE_FIRST = 2'd0;
  localparam logic [MW-1:0] MODE_SPARE = 2'd3;
  localparam logic [CW-1:0] ACT_SPARE = 2'd3;

  typedef enum logic [1:0] {JOB_CMD, JOB_MODE, JOB_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e kind;
    logic [CW-1:0] act;
    logic [AW-1:0] p_lo;
    logic [AW-1:0] p_hi;
    logic [IW-1:0] pid;
    logic [RW-1:0] req;
    logic [MW-1:0] mode;
    int gap;
  } job_t;

  typedef struct {
    logic [SW-1:0] status;
    logic [AW-1:0] g_lo;
    logic [AW-1:0] g_hi;
    logic [AW:0] free_tot;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic cfg_we = 1'b0;
  logic [MW-1:0] cfg_wdata = '0;
  logic [CW-1:0] action = '0;
  logic [AW-1:0] part_start = '0;
  logic [AW-1:0] part_end = '0;
  logic [IW-1:0] process_id = '0;
  logic [RW-1:0] request_size = '0;
  logic busy, done;
  logic [SW-1:0] status;
  logic [AW-1:0] grant_start, grant_end;
  logic [AW:0] free_total;

  job_t jobs[$];
  grant_t grants_due[$];
  int mismatches = 0;
  int waited = 0;
  int idle_cycles = 0;

  // allocator shadow state
  int tbl_lo[NSEG];
  int tbl_hi[NSEG];
  int tbl_own[NSEG];
  bit tbl_used[NSEG];
  int tbl_n = 0;
  logic [MW-1:0] fit_mode = MODE_FIRST;

  fit_segment_allocator dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .action_i(action), .part_start_i(part_start), .part_end_i(part_end),
    .process_id_i(process_id), .request_size_i(request_size),
    .done_o(done), .status_o(status), .grant_start_o(grant_start),
    .grant_end_o(grant_end), .free_total_o(free_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int owner_slot(int pid);
    for (int i = 0; i < tbl_n; i++)
      if (tbl_used[i] && tbl_own[i] == pid) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int k);
    for (int i = k; i + 1 < tbl_n; i++) begin
      tbl_lo[i] = tbl_lo[i+1];
      tbl_hi[i] = tbl_hi[i+1];
      tbl_own[i] = tbl_own[i+1];
      tbl_used[i] = tbl_used[i+1];
    end
    tbl_n--;
  endfunction

  function automatic logic [SW-1:0] place(int pid, int req, output int g_lo,
                                           output int g_hi);
    int pick, best, sz;
    bit found;
    pick = 0;
    best = 0;
    found = 0;
    g_lo = 0;
    g_hi = 0;
    if (owner_slot(pid) >= 0) return fsa_pkg::ST_ID_USED;
    if (req == 0) return fsa_pkg::ST_BAD;
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_used[i]) continue;
      sz = tbl_hi[i] - tbl_lo[i] + 1;
      if (sz < req) continue;
      if (fit_mode == fsa_pkg::MODE_BEST) begin
        if (!found || sz < best) begin found = 1; pick = i; best = sz; end
      end else if (fit_mode == fsa_pkg::MODE_WORST) begin
        if (!found || sz > best) begin found = 1; pick = i; best = sz; end
      end else begin
        found = 1;
        pick = i;
        break;
      end
    end
    if (!found) return fsa_pkg::ST_NO_FIT;
    sz = tbl_hi[pick] - tbl_lo[pick] + 1;
    if (sz > req && tbl_n >= NSEG) return fsa_pkg::ST_BAD;
    g_lo = tbl_lo[pick];
    g_hi = tbl_lo[pick] + req - 1;
    if (sz > req) begin
      // open a slot for the remainder just after the grant
      for (int i = tbl_n; i > pick + 1; i--) begin
        tbl_lo[i] = tbl_lo[i-1];
        tbl_hi[i] = tbl_hi[i-1];
        tbl_own[i] = tbl_own[i-1];
        tbl_used[i] = tbl_used[i-1];
      end
      tbl_lo[pick+1] = g_hi + 1;
      tbl_hi[pick+1] = tbl_hi[pick];
      tbl_own[pick+1] = 0;
      tbl_used[pick+1] = 0;
      tbl_n++;
      tbl_hi[pick] = g_hi;
    end
    tbl_used[pick] = 1;
    tbl_own[pick] = pid;
    return fsa_pkg::ST_OK;
  endfunction

  function automatic logic [SW-1:0] release_id(int pid);
    int k, i;
    k = owner_slot(pid);
    if (k < 0) return fsa_pkg::ST_NOT_FOUND;
    tbl_used[k] = 0;
    tbl_own[k] = 0;
    i = 0;
    while (i + 1 < tbl_n) begin
      if (!tbl_used[i] && !tbl_used[i+1] && tbl_hi[i] + 1 == tbl_lo[i+1]) begin
        tbl_hi[i] = tbl_hi[i+1];
        drop_slot(i + 1);
      end else begin
        i++;
      end
    end
    return fsa_pkg::ST_OK;
  endfunction

  function automatic grant_t predict_grant(job_t j);
    grant_t g;
    int lo, hi, sum;
    lo = 0;
    hi = 0;
    sum = 0;
    g.status = fsa_pkg::ST_BAD;
    case (j.act)
      fsa_pkg::ACT_APPEND: begin
        if (j.p_hi >= j.p_lo && tbl_n < NSEG) begin
          tbl_lo[tbl_n] = int'(j.p_lo);
          tbl_hi[tbl_n] = int'(j.p_hi);
          tbl_own[tbl_n] = 0;
          tbl_used[tbl_n] = 0;
          tbl_n++;
          g.status = fsa_pkg::ST_OK;
        end
      end
      fsa_pkg::ACT_ALLOC: g.status = place(int'(j.pid), int'(j.req), lo, hi);
      fsa_pkg::ACT_FREE: g.status = release_id(int'(j.pid));
      default: g.status = fsa_pkg::ST_BAD;
    endcase
    for (int i = 0; i < tbl_n; i++)
      if (!tbl_used[i]) sum += tbl_hi[i] - tbl_lo[i] + 1;
    if (sum > FREE_CAP) sum = FREE_CAP;
    g.g_lo = (g.status == fsa_pkg::ST_OK && j.act == fsa_pkg::ACT_ALLOC) ? lo[AW-1:0] : '0;
    g.g_hi = (g.status == fsa_pkg::ST_OK && j.act == fsa_pkg::ACT_ALLOC) ? hi[AW-1:0] : '0;
    g.free_tot = sum[AW:0];
    return g;
  endfunction

  // driver: present one command at a time, mode writes only once drained
  always @(posedge clk or negedge rst_n) begin
    logic go, we;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      waited <= 0;
    end else begin
      go = start;
      we = 1'b0;
      if (start && !busy) begin
        grants_due.push_back(predict_grant('{JOB_CMD, action, part_start, part_end,
                                             process_id, request_size, MODE_FIRST, 0}));
        go = 1'b0;
      end
      if (!go && jobs.size() > 0) begin
        case (jobs[0].kind)
          JOB_CMD: begin
            if (waited < jobs[0].gap) begin
              waited <= waited + 1;
            end else begin
              waited <= 0;
              action <= jobs[0].act;
              part_start <= jobs[0].p_lo;
              part_end <= jobs[0].p_hi;
              process_id <= jobs[0].pid;
              request_size <= jobs[0].req;
              go = 1'b1;
              void'(jobs.pop_front());
            end
          end
          default: begin
            if (grants_due.size() == 0 && !busy && !done) begin
              if (jobs[0].kind == JOB_MODE) begin
                we = 1'b1;
                cfg_wdata <= jobs[0].mode;
                fit_mode = jobs[0].mode;
              end
              void'(jobs.pop_front());
            end
          end
        endcase
      end
      start <= go;
      cfg_we <= we;
    end
  end

  // monitor: every strobe is one result transfer
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && done) begin
      if (grants_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status %0d", status);
      end else begin
        want = grants_due.pop_front();
        if (status !== want.status || grant_start !== want.g_lo ||
            grant_end !== want.g_hi || free_total !== want.free_tot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d %0d..%0d free %0d, got st %0d %0d..%0d free %0d",
                     want.status, want.g_lo, want.g_hi, want.free_tot,
                     status, grant_start, grant_end, free_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL fit_segment_allocator");
      $finish;
    end
  end

  task automatic add_cmd(logic [CW-1:0] act, int lo, int hi, int pid, int req);
    jobs.push_back('{JOB_CMD, act, lo[AW-1:0], hi[AW-1:0], pid[IW-1:0], req[RW-1:0],
                     MODE_FIRST, $urandom_range(0, 5)});
  endtask

  task automatic add_mode(logic [MW-1:0] m);
    jobs.push_back('{JOB_MODE, fsa_pkg::ACT_APPEND, '0, '0, '0, '0, m, 0});
  endtask

  initial begin
    logic [MW-1:0] modes[5];
    int cursor, len, pick, pid, req;
    modes = '{fsa_pkg::MODE_BEST, fsa_pkg::MODE_WORST, MODE_SPARE, MODE_FIRST,
              fsa_pkg::MODE_BEST};

    add_mode(MODE_FIRST);
    add_cmd(fsa_pkg::ACT_APPEND, 200, 100, 0, 0);      // end below start
    add_cmd(fsa_pkg::ACT_APPEND, 0, 65535, 0, 0);
    add_cmd(fsa_pkg::ACT_APPEND, 0, 65535, 0, 0);      // free total saturates
    add_cmd(fsa_pkg::ACT_ALLOC, 0, 0, 0, 0);           // zero size
    add_cmd(fsa_pkg::ACT_ALLOC, 0, 0, 255, 65535);
    add_cmd(fsa_pkg::ACT_ALLOC, 0, 0, 255, 1);         // id in use
    add_cmd(fsa_pkg::ACT_ALLOC, 0, 0, 3, 65535);
    add_cmd(fsa_pkg::ACT_ALLOC, 0, 0, 4, 65535);       // nothing fits
    add_cmd(fsa_pkg::ACT_FREE, 0, 0, 7, 0);            // unknown id
    add_cmd(ACT_SPARE, 0, 0, 0, 0);
    add_cmd(fsa_pkg::ACT_FREE, 0, 0, 255, 0);
    add_cmd(fsa_pkg::ACT_FREE, 0, 0, 3, 0);
    // fill the table with touching pairs, then hit it full
    for (int i = 0; i < 30; i++)
      add_cmd(fsa_pkg::ACT_APPEND, 1000 + 2 * i, 1001 + 2 * i, 0, 0);
    add_cmd(fsa_pkg::ACT_APPEND, 5, 6, 0, 0);
    add_mode(fsa_pkg::MODE_BEST);
    add_cmd(fsa_pkg::ACT_ALLOC, 0, 0, 9, 2);
    add_cmd(fsa_pkg::ACT_ALLOC, 0, 0, 10, 1);          // split with no slot left
    add_cmd(fsa_pkg::ACT_FREE, 0, 0, 9, 0);            // merges the touching run

    cursor = 2000;
    for (int ph = 0; ph < 5; ph++) begin
      add_mode(modes[ph]);
      for (int n = 0; n < 80; n++) begin
        if (n == 40 && ph % 2 == 0) jobs.push_back('{JOB_DRAIN, fsa_pkg::ACT_APPEND, '0, '0,
                                                     '0, '0, MODE_FIRST, 0});
        pick = $urandom_range(0, 99);
        pid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 11);
        req = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 300);
        if (pick < 18) begin
          len = $urandom_range(1, 600);
          if ($urandom_range(0, 4) == 0) cursor += $urandom_range(1, 50);
          if (cursor + len > 65535) cursor = $urandom_range(0, 500);
          add_cmd(fsa_pkg::ACT_APPEND, cursor, cursor + len - 1, 0, 0);
          cursor += len;
        end else if (pick < 21) begin
          add_cmd(fsa_pkg::ACT_APPEND, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  0, 0);
        end else if (pick < 62) begin
          add_cmd(fsa_pkg::ACT_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  pid, req);
        end else if (pick < 97) begin
          add_cmd(fsa_pkg::ACT_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  pid, $urandom_range(0, 65535));
        end else begin
          add_cmd(ACT_SPARE, $urandom_range(0, 65535), $urandom_range(0, 65535), pid, req);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (jobs.size() > 0 || start || grants_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && grants_due.size() == 0) $display("PASS fit_segment_allocator");
    else $display("FAIL fit_segment_allocator");
    $finish;
  end

endmodule

// ===== files.f =====
sv/fsa_pkg.sv
sv/fsa_cell.sv
sv/fit_segment_allocator.sv
sv/fsa_checker.sv
tb/sv/tb.sv
